>>> sv/klsel_pkg.sv
// klsel_pkg: shared types and constants for the k-largest select block.
// No dependencies; used by klsel_ctrl, klsel_dp and k_largest_select.
package klsel_pkg;

    localparam int VALUE_W      = 32;  // width of one data word
    localparam int CFG_W        = 5;   // width of the keep_count register
    localparam int MAX_KEEP_DEF = 16;  // default store depth

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [CFG_W-1:0]          t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic insert;  // take the input word into the sorted store
        logic load;    // set up the emit window from the store after insert
        logic emit;    // put out one kept word
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic emit_last;  // the word being emitted now is the final one
    } t_stat;

endpackage

>>> sv/k_largest_select.sv
// k_largest_select: top level, streaming top-k select of signed words.
// Depends on klsel_pkg, klsel_ctrl and klsel_dp.
//
// Feeds a set of signed 32-bit words one per start pulse; the block keeps
// the largest keep_count of them (duplicates kept) in a sorted store. A
// word without i_last is taken into the store and busy stays low, so words may be
// presented back to back. A word with i_last is first taken into the store
// in its accept cycle; busy then rises and stays high while the n kept words
// (n = min(words loaded, keep_count)) leave in ascending order, one per
// cycle, each valid on o_largest_value for exactly one cycle while o_strobe
// is high, the last one with o_final_res set. The store has a single read
// port. The receiver cannot stall the output: it must take every word in
// its strobe cycle.
// The store then empties and the next set may start as soon as busy falls.
// keep_count of zero acts as one; above MAX_KEEP it saturates to MAX_KEEP.
// Write keep_count only while no set is being emitted.
module k_largest_select #(
    parameter int MAX_KEEP = klsel_pkg::MAX_KEEP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command side
    input  logic              start,
    output logic              busy,
    input  klsel_pkg::t_value i_value,
    input  logic              i_last,
    // config register keep_count
    input  logic              i_cfg_we,
    input  klsel_pkg::t_cfg   i_cfg_wdata,
    // result side
    output logic              o_strobe,
    output klsel_pkg::t_value o_largest_value,
    output logic              o_final_res
);

    klsel_pkg::t_cmd  cmd;
    klsel_pkg::t_stat stat;

    // Sequencer: idle takes words in, emit walks the kept window.
    klsel_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_last),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Sorted store with one compare cell per entry.
    klsel_dp #(
        .MAX_KEEP (MAX_KEEP)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_value         (i_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_largest_value (o_largest_value),
        .o_final_res     (o_final_res),
        .o_strobe        (o_strobe)
    );

endmodule

>>> sv/klsel_ctrl.sv
// klsel_ctrl: two-state sequencer (take words in, then emit a set).
// Depends on klsel_pkg for the command and status structs.
module klsel_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_last,
    input  klsel_pkg::t_stat i_stat,
    output klsel_pkg::t_cmd  o_cmd,
    output logic             o_busy
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.insert = 1'b1;
                    if (i_last) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state == ST_EMIT);

endmodule

>>> sv/klsel_dp.sv
// klsel_dp: sorted store of kept words, insertion cells, emit index and
// output register. Depends on klsel_pkg; driven by klsel_ctrl commands.
module klsel_dp #(
    parameter int MAX_KEEP = klsel_pkg::MAX_KEEP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  klsel_pkg::t_cmd   i_cmd,
    output klsel_pkg::t_stat  o_stat,
    input  klsel_pkg::t_value i_value,
    input  logic              i_cfg_we,
    input  klsel_pkg::t_cfg   i_cfg_wdata,
    output klsel_pkg::t_value o_largest_value,
    output logic              o_final_res,
    output logic              o_strobe
);

    localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int FW = $clog2(MAX_KEEP + 1);
    localparam int KW = (FW > klsel_pkg::CFG_W) ? FW : klsel_pkg::CFG_W;

    klsel_pkg::t_value r_kept [MAX_KEEP];
    klsel_pkg::t_value n_kept [MAX_KEEP];
    logic [FW-1:0]     r_fill;
    klsel_pkg::t_cfg   r_keep;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     r_end;
    klsel_pkg::t_value r_out;
    logic              r_final;
    logic              r_strobe;

    logic [KW-1:0]     keep_ext;
    logic [FW-1:0]     k_eff;
    logic              room;
    logic [MAX_KEEP-1:0] lt;
    logic [MAX_KEEP-1:0] gt;
    logic [FW-1:0]     fill_next;
    logic [FW-1:0]     emit_n;

    // effective count: zero reads as one, saturate at store depth
    always_comb begin
        keep_ext = KW'(r_keep);
        if (keep_ext == '0) begin
            k_eff = FW'(1);
        end else if (keep_ext > KW'(MAX_KEEP)) begin
            k_eff = FW'(MAX_KEEP);
        end else begin
            k_eff = FW'(keep_ext);
        end
    end

    // per-cell compares against the incoming word
    always_comb begin
        for (int i = 0; i < MAX_KEEP; i++) begin
            lt[i] = (FW'(i) < r_fill) && (i_value < r_kept[i]);
            gt[i] = (FW'(i) < r_fill) && (r_kept[i] < i_value);
        end
    end

    assign room      = (r_fill < k_eff) && (r_fill != FW'(MAX_KEEP));
    assign fill_next = room ? r_fill + FW'(1) : r_fill;
    assign emit_n    = (fill_next < k_eff) ? fill_next : k_eff;

    always_comb begin
        for (int i = 0; i < MAX_KEEP; i++) begin
            n_kept[i] = r_kept[i];
        end
        if (room) begin
            // grow: larger words slide up one cell, word drops into the gap
            for (int i = 0; i < MAX_KEEP; i++) begin
                if ((FW'(i) < r_fill && lt[i]) || FW'(i) == r_fill) begin
                    n_kept[i] = i_value;
                end
            end
            for (int i = 1; i < MAX_KEEP; i++) begin
                if (lt[i-1]) begin
                    n_kept[i] = r_kept[i-1];
                end
            end
        end else begin
            // full: smallest falls out, smaller words slide down
            for (int i = 0; i < MAX_KEEP; i++) begin
                if (gt[i]) begin
                    n_kept[i] = i_value;
                end
            end
            for (int i = 0; i < MAX_KEEP - 1; i++) begin
                if (gt[i+1]) begin
                    n_kept[i] = r_kept[i+1];
                end
            end
        end
    end

    assign o_stat.emit_last = (r_idx == r_end);

    // store contents carry no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            for (int i = 0; i < MAX_KEEP; i++) begin
                r_kept[i] <= n_kept[i];
            end
        end
        if (i_cmd.load) begin
            r_idx <= IW'(fill_next - emit_n);
            r_end <= IW'(fill_next - FW'(1));
        end else if (i_cmd.emit) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.emit) begin
            r_out   <= r_kept[r_idx];
            r_final <= (r_idx == r_end);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_keep   <= klsel_pkg::t_cfg'(1);
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_keep <= i_cfg_wdata;
            end
            if (i_cmd.emit && r_idx == r_end) begin
                r_fill <= '0;
            end else if (i_cmd.insert) begin
                r_fill <= fill_next;
            end
            r_strobe <= i_cmd.emit;
        end
    end

    assign o_largest_value = r_out;
    assign o_final_res     = r_final;
    assign o_strobe        = r_strobe;

endmodule
